// ===== hw/rtl/vpiol_pkg.sv =====
// Shared types and constants for the velocity PI controller with obstacle limiting.
package vpiol_pkg;

    // field and state widths
    localparam int WHEEL_W  = 16;
    localparam int OFFS_W   = 8;
    localparam int DIST_W   = 10;
    localparam int TILT_W   = 17;
    localparam int DRIVE_W  = 32;
    localparam int FILT_W   = 28;
    localparam int POS_W    = 30;
    localparam int TGT_W    = 18;
    localparam int SUM_W    = 32;
    localparam int FRAC_W   = 8;
    localparam int GAIN_SH  = 24;

    // shift-add multiplier
    localparam int MCAND_W  = 36;
    localparam int MPLIER_W = 16;
    localparam int ACC_W    = 54;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DODGE_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT     = 3'd6;

    localparam logic [9:0]  RST_BASE_SPEED     = 10'd120;
    localparam logic [7:0]  RST_DIST_THRESHOLD = 8'd45;
    localparam logic [7:0]  RST_DODGE_DISTANCE = 8'd20;
    localparam logic [15:0] RST_SPEED_GAIN     = 16'd3328;
    localparam logic [15:0] RST_INTEGRAL_GAIN  = 16'd5308;
    localparam logic [19:0] RST_INTEGRAL_LIMIT = 20'd100000;
    localparam logic [15:0] RST_TILT_LIMIT     = 16'd10240;

    // move commands
    localparam logic [1:0] CMD_STOP    = 2'd0;
    localparam logic [1:0] CMD_FWD     = 2'd1;
    localparam logic [1:0] CMD_REVERSE = 2'd2;

    // low-pass weights, 0.8 and 0.2 in Q8
    localparam logic [MPLIER_W-1:0] FILT_OLD_GAIN = 16'd205;
    localparam logic [MPLIER_W-1:0] FILT_NEW_GAIN = 16'd51;

    localparam logic signed [TGT_W-1:0] SPEED_MARGIN = 18'sd10;
    localparam logic signed [TGT_W-1:0] DODGE_STEP   = 18'sd10;
    localparam logic signed [OFFS_W-1:0] OFFS_BRAKE_MIN = -8'sd10;

    localparam logic signed [FILT_W-1:0] FILT_MAX = 28'sh7FFFFFF;
    localparam logic signed [FILT_W-1:0] FILT_MIN = 28'sh8000000;

    typedef struct packed {
        logic                       start;
        logic                       clear;
        logic signed [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0]        mplier;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage

// ===== hw/rtl/vpiol_if.sv =====
// Request channel interfaces: controller sample in, controller result out.
interface vpiol_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [vpiol_pkg::WHEEL_W-1:0]   wheel_speed;
    logic [1:0]                             move_command;
    logic signed [vpiol_pkg::OFFS_W-1:0]    remote_offset;
    logic signed [vpiol_pkg::WHEEL_W-1:0]   measured_speed;
    logic [vpiol_pkg::DIST_W-1:0]           obstacle_distance;
    logic signed [vpiol_pkg::TILT_W-1:0]    tilt_angle;

    modport source (
        output valid, wheel_speed, move_command, remote_offset, measured_speed,
               obstacle_distance, tilt_angle,
        input  ready
    );
    modport sink (
        input  valid, wheel_speed, move_command, remote_offset, measured_speed,
               obstacle_distance, tilt_angle,
        output ready
    );
endinterface

interface vpiol_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [vpiol_pkg::DRIVE_W-1:0]   drive;
    logic                                   buzzer_write;
    logic                                   buzzer_on;
    logic                                   command_clear;

    modport source (
        output valid, drive, buzzer_write, buzzer_on, command_clear,
        input  ready
    );
    modport sink (
        input  valid, drive, buzzer_write, buzzer_on, command_clear,
        output ready
    );
endinterface

// ===== hw/rtl/vpiol_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier, accumulating.
module vpiol_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  vpiol_pkg::t_mul_req                    i_req,
    output vpiol_pkg::t_mul_sts                    o_sts,
    output logic signed [vpiol_pkg::ACC_W-1:0]     o_acc
);

    localparam int EXT_W = vpiol_pkg::ACC_W - vpiol_pkg::MCAND_W;

    logic                                   r_busy;
    logic signed [vpiol_pkg::ACC_W-1:0]     r_mcand;
    logic [vpiol_pkg::MPLIER_W-1:0]         r_mplier;
    logic signed [vpiol_pkg::ACC_W-1:0]     r_acc;
    logic                                   w_done;

    // finished once no multiplier bits remain
    assign w_done = r_busy && (r_mplier == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand  <= {{EXT_W{i_req.mcand[vpiol_pkg::MCAND_W-1]}}, i_req.mcand};
            r_mplier <= i_req.mplier;
            if (i_req.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy && !w_done) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = w_done;
    assign o_acc      = r_acc;

endmodule

// ===== hw/rtl/velocity_pi_with_obstacle_limit.sv =====
// Requests are taken one at a time: a new request is accepted only in the idle state, after the
//   previous result is loaded into the output register; a single shift-add multiplier, one
//   multiplier bit per cycle, forms all four products in turn.
// Reset: configuration returns to defaults, filter and integral state clear to zero,
//   no result pending.
module velocity_pi_with_obstacle_limit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [vpiol_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [vpiol_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    vpiol_in_if.sink                                i_in,
    vpiol_out_if.source                             o_out
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MF   = 7'b0000010,
        S_MW   = 7'b0000100,
        S_POS  = 7'b0001000,
        S_MS   = 7'b0010000,
        S_MI   = 7'b0100000,
        S_DRV  = 7'b1000000
    } t_state;

    localparam int TGT_W  = vpiol_pkg::TGT_W;
    localparam int SUM_W  = vpiol_pkg::SUM_W;
    localparam int FILT_W = vpiol_pkg::FILT_W;
    localparam int POS_W  = vpiol_pkg::POS_W;
    localparam int ACC_W  = vpiol_pkg::ACC_W;
    localparam int MC_W   = vpiol_pkg::MCAND_W;
    localparam int FRAC_W = vpiol_pkg::FRAC_W;
    localparam int SH_W   = ACC_W - FRAC_W;
    localparam int Q_W    = ACC_W - vpiol_pkg::GAIN_SH;

    // configuration
    logic [9:0]  r_base_speed;
    logic [7:0]  r_dist_thr;
    logic [7:0]  r_dodge_dist;
    logic [15:0] r_speed_gain;
    logic [15:0] r_integral_gain;
    logic [19:0] r_integral_limit;
    logic [15:0] r_tilt_limit;

    t_state                         r_state, n_state;
    logic signed [FILT_W-1:0]       r_filt, n_filt;
    logic signed [POS_W-1:0]        r_pos, n_pos;
    logic signed [TGT_W-1:0]        r_target;
    logic signed [15:0]             r_wheel;
    logic                           r_tilt, r_bw, r_bon;

    logic                           r_out_valid;
    logic signed [31:0]             r_drive;
    logic                           r_out_bw, r_out_bon, r_out_clr;

    vpiol_pkg::t_mul_req            w_mul_req;
    vpiol_pkg::t_mul_sts            w_mul_sts;
    logic signed [ACC_W-1:0]        w_acc;

    logic                           w_in_fire, w_out_fire, w_out_load;

    // ---------------- target, buzzer and tilt from the request ----------------
    logic signed [TGT_W-1:0] w_base, w_meas, w_dist, w_thr, w_offs, w_tilt, w_tlim;
    logic signed [TGT_W-1:0] w_cmd_tgt, w_rem_tgt, w_target;
    logic                    w_limiting, w_has_offs, w_tilted;

    always_comb begin
        w_base = $signed({8'b0, r_base_speed});
        w_meas = TGT_W'(i_in.measured_speed);
        w_dist = $signed({8'b0, i_in.obstacle_distance});
        w_thr  = $signed({10'b0, r_dist_thr});
        w_offs = TGT_W'(i_in.remote_offset);
        w_tilt = TGT_W'(i_in.tilt_angle);
        w_tlim = $signed({2'b0, r_tilt_limit});

        case (i_in.move_command)
            vpiol_pkg::CMD_FWD:     w_cmd_tgt = w_base;
            vpiol_pkg::CMD_REVERSE: w_cmd_tgt = -w_base;
            default:                w_cmd_tgt = '0;
        endcase

        w_has_offs = (i_in.remote_offset != '0);
        w_limiting = w_has_offs && (w_meas + vpiol_pkg::SPEED_MARGIN > w_dist)
                     && (i_in.obstacle_distance < {2'b0, r_dist_thr});

        if (!w_has_offs) begin
            w_rem_tgt = '0;
        end else if (w_limiting && (i_in.remote_offset > vpiol_pkg::OFFS_BRAKE_MIN)) begin
            w_rem_tgt = -(w_meas + w_thr - w_dist);
        end else begin
            w_rem_tgt = w_offs;
        end

        w_target = w_cmd_tgt + w_rem_tgt;
        if (i_in.obstacle_distance < {2'b0, r_dodge_dist}) begin
            w_target = w_target - vpiol_pkg::DODGE_STEP;
        end

        w_tilted = (w_tilt > w_tlim) || (w_tilt < -w_tlim);
    end

    // ---------------- filter saturation and integral clamp ----------------
    logic signed [SH_W-1:0]     w_filt_sh;
    logic [SH_W-FILT_W:0]       w_filt_hi;
    logic signed [FILT_W-1:0]   w_filt_sat;
    logic signed [25:0]         w_tgt_sh;
    logic signed [SUM_W-1:0]    w_psum, w_lim, w_nlim;
    logic signed [POS_W-1:0]    w_pos_clamp;

    always_comb begin
        // arithmetic shift gives the floor of the Q8 product
        w_filt_sh = w_acc[ACC_W-1:FRAC_W];
        w_filt_hi = w_filt_sh[SH_W-1:FILT_W-1];
        if ((w_filt_hi == '0) || (w_filt_hi == '1)) begin
            w_filt_sat = w_filt_sh[FILT_W-1:0];
        end else if (w_filt_sh[SH_W-1]) begin
            w_filt_sat = vpiol_pkg::FILT_MIN;
        end else begin
            w_filt_sat = vpiol_pkg::FILT_MAX;
        end

        w_tgt_sh = {r_target, 8'h00};
        w_psum   = SUM_W'(r_pos) + SUM_W'(r_filt) + SUM_W'(w_tgt_sh);
        w_lim    = $signed({4'b0, r_integral_limit, 8'h00});
        w_nlim   = -w_lim;
        if (w_psum > w_lim) begin
            w_pos_clamp = w_lim[POS_W-1:0];
        end else if (w_psum < w_nlim) begin
            w_pos_clamp = w_nlim[POS_W-1:0];
        end else begin
            w_pos_clamp = w_psum[POS_W-1:0];
        end
    end

    // ---------------- drive: Q24 to integer, toward zero ----------------
    logic signed [Q_W-1:0]  w_q;
    logic                   w_round_up;
    logic signed [31:0]     w_drive;

    always_comb begin
        w_round_up = w_acc[ACC_W-1] && (w_acc[vpiol_pkg::GAIN_SH-1:0] != '0);
        w_q        = w_acc[ACC_W-1:vpiol_pkg::GAIN_SH] + Q_W'(w_round_up);
        // magnitude stays under 2^28, so the 32-bit limit is never reached
        w_drive    = r_tilt ? '0 : 32'(w_q);
    end

    // ---------------- sequencer ----------------
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_out_load = (r_state == S_DRV) && (!r_out_valid || w_out_fire);

    always_comb begin
        n_state          = r_state;
        n_filt           = r_filt;
        n_pos            = r_pos;
        w_mul_req.start  = 1'b0;
        w_mul_req.clear  = 1'b0;
        w_mul_req.mcand  = MC_W'(r_filt);
        w_mul_req.mplier = vpiol_pkg::FILT_OLD_GAIN;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.clear = 1'b1;
                    n_state         = S_MF;
                end
            end
            S_MF: begin
                // wheel*51 lands at Q8 so one floor shift covers both terms
                w_mul_req.mcand  = MC_W'($signed({r_wheel, 8'h00}));
                w_mul_req.mplier = vpiol_pkg::FILT_NEW_GAIN;
                if (w_mul_sts.done) begin
                    w_mul_req.start = 1'b1;
                    n_state         = S_MW;
                end
            end
            S_MW: begin
                if (w_mul_sts.done) begin
                    n_filt  = w_filt_sat;
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_pos            = r_tilt ? '0 : w_pos_clamp;
                w_mul_req.start  = 1'b1;
                w_mul_req.clear  = 1'b1;
                w_mul_req.mcand  = MC_W'($signed({r_filt, 8'h00}));
                w_mul_req.mplier = r_speed_gain;
                n_state          = S_MS;
            end
            S_MS: begin
                w_mul_req.mcand  = MC_W'(r_pos);
                w_mul_req.mplier = r_integral_gain;
                if (w_mul_sts.done) begin
                    w_mul_req.start = 1'b1;
                    n_state         = S_MI;
                end
            end
            S_MI: begin
                if (w_mul_sts.done) begin
                    n_state = S_DRV;
                end
            end
            S_DRV: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    vpiol_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_sts   (w_mul_sts),
        .o_acc   (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_filt  <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_filt  <= n_filt;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_target <= w_target;
            r_wheel  <= i_in.wheel_speed;
            r_tilt   <= w_tilted;
            r_bw     <= w_has_offs;
            r_bon    <= w_limiting;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed     <= vpiol_pkg::RST_BASE_SPEED;
            r_dist_thr       <= vpiol_pkg::RST_DIST_THRESHOLD;
            r_dodge_dist     <= vpiol_pkg::RST_DODGE_DISTANCE;
            r_speed_gain     <= vpiol_pkg::RST_SPEED_GAIN;
            r_integral_gain  <= vpiol_pkg::RST_INTEGRAL_GAIN;
            r_integral_limit <= vpiol_pkg::RST_INTEGRAL_LIMIT;
            r_tilt_limit     <= vpiol_pkg::RST_TILT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vpiol_pkg::CFG_BASE_SPEED:     r_base_speed     <= i_cfg_data[9:0];
                vpiol_pkg::CFG_DIST_THRESHOLD: r_dist_thr       <= i_cfg_data[7:0];
                vpiol_pkg::CFG_DODGE_DISTANCE: r_dodge_dist     <= i_cfg_data[7:0];
                vpiol_pkg::CFG_SPEED_GAIN:     r_speed_gain     <= i_cfg_data[15:0];
                vpiol_pkg::CFG_INTEGRAL_GAIN:  r_integral_gain  <= i_cfg_data[15:0];
                vpiol_pkg::CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data;
                vpiol_pkg::CFG_TILT_LIMIT:     r_tilt_limit     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_drive   <= w_drive;
            r_out_bw  <= r_bw;
            r_out_bon <= r_bon;
            r_out_clr <= r_tilt;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.drive         = r_drive;
    assign o_out.buzzer_write  = r_out_bw;
    assign o_out.buzzer_on     = r_out_bon;
    assign o_out.command_clear = r_out_clr;

    // ---------------- assertions ----------------
    a_idle_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_mul_sts.busy)
        else $error("multiplier busy while taking a new request");

    a_mul_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_req.start |-> (!w_mul_sts.busy || w_mul_sts.done))
        else $error("multiplier restarted mid-product");

    a_tilt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.command_clear) |-> (o_out.drive == '0))
        else $error("nonzero drive on tilt fault");

    a_buzz_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.buzzer_on) |-> o_out.buzzer_write)
        else $error("buzzer on without buzzer write");

endmodule
